/* hdl/focpwm_pkg.sv */
package focpwm_pkg;

    typedef struct packed {
        logic signed [15:0] phase_a_current;
        logic signed [15:0] phase_b_current;
        logic [15:0]        rotor_angle;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] current_d;
        logic signed [15:0] current_q;
        logic [15:0]        compare_a;
        logic [15:0]        compare_b;
        logic [15:0]        compare_c;
    } result_t;

    // d/q current side band that rides along the pwm half of the pipe
    typedef struct packed {
        logic signed [15:0] d;
        logic signed [15:0] q;
    } dq_t;

    // configuration register map
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_VOLTAGE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_D_CMD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_Q_CMD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 4'd3;

    localparam logic [15:0] BUS_VOLTAGE_RST = 16'd7168;
    localparam logic [15:0] VOLT_D_CMD_RST  = 16'd0;
    localparam logic [15:0] VOLT_Q_CMD_RST  = 16'd768;
    localparam logic [15:0] PWM_PERIOD_RST  = 16'd3750;

    // fixed-point constants
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [17:0] INV_SQRT3_Q16  = 18'sd37837;
    localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;

    localparam int SIN_W = 15;

    // compare divider
    localparam int QUOT_W     = 16;
    localparam int NUM_W      = 34;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
    localparam int PHASES     = 3;

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > 21'sd32767)
            r = 16'sh7fff;
        else if (v < -21'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

/* hdl/foc_open_loop_pwm_compare.sv */
// data path: an input transfer passes the pipeline stages, the divider stages last, into the output register
// throughput: one item per cycle; every stage advances on one enable, so a stall freezes all
// of it, and the output register plus one skid entry keep input accepting while a result waits
// reset: rst_n is asynchronous, active low; it clears all valid bits and loads the
// configuration registers with their defaults; the sine table is a constant rom, no fill pass
module foc_open_loop_pwm_compare #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int ANGLE_BITS       = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  focpwm_pkg::sample_t                  sample,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output focpwm_pkg::result_t                  result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [focpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                          cfg_data
);

    localparam int DEPTH  = SINE_TABLE_DEPTH;
    localparam int IDX_W  = $clog2(4 * DEPTH);
    localparam int AW     = $clog2(DEPTH + 1);
    localparam int PROD_W = ANGLE_BITS + IDX_W;
    localparam int NPH    = focpwm_pkg::PHASES;
    localparam int NSTG   = 9 + focpwm_pkg::DIV_STAGES;   // pipeline stages
    localparam int NCUR   = 6 + focpwm_pkg::DIV_STAGES;   // stages carrying id/iq

    // ---------------------------------------------------------------
    // configuration registers, written only while the pipe is empty
    // ---------------------------------------------------------------
    logic [15:0]        bus_reg;
    logic signed [15:0] vd_reg;
    logic signed [15:0] vq_reg;
    logic [15:0]        period_reg;
    logic [15:0]        bus_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg    <= focpwm_pkg::BUS_VOLTAGE_RST;
            vd_reg     <= focpwm_pkg::VOLT_D_CMD_RST;
            vq_reg     <= focpwm_pkg::VOLT_Q_CMD_RST;
            period_reg <= focpwm_pkg::PWM_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                focpwm_pkg::REG_BUS_VOLTAGE: bus_reg    <= cfg_data;
                focpwm_pkg::REG_VOLT_D_CMD:  vd_reg     <= cfg_data;
                focpwm_pkg::REG_VOLT_Q_CMD:  vq_reg     <= cfg_data;
                focpwm_pkg::REG_PWM_PERIOD:  period_reg <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // a zero bus voltage divides as one
    assign bus_eff = (bus_reg == 16'd0) ? 16'd1 : bus_reg;

    // ---------------------------------------------------------------
    // pipeline control: one enable, valid bits shift with the data
    // ---------------------------------------------------------------
    logic            en;
    logic            space;
    logic [NSTG-1:0] v_reg;

    assign en           = space;
    assign sample_ready = en;
    // configuration transfers wait until no item is in flight
    assign cfg_ready    = (v_reg == '0) && !result_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NSTG-2:0], sample_valid};
    end

    // ---------------------------------------------------------------
    // stage 1: angle to table index and quadrant, clarke beta product
    // ---------------------------------------------------------------
    logic [ANGLE_BITS+15:0] ang_wide;
    logic [ANGLE_BITS-1:0]  ang;
    logic [PROD_W-1:0]      ang_prod;
    logic [IDX_W-1:0]       idx;
    logic [1:0]             quad;
    logic [1:0]             cquad;
    logic [IDX_W-1:0]       pos_w;
    logic [AW-1:0]          pos;
    logic signed [17:0]     ab_sum;

    logic [AW-1:0]          sin_addr_reg;
    logic [AW-1:0]          cos_addr_reg;
    logic                   sin_neg_s1_reg;
    logic                   cos_neg_s1_reg;
    logic signed [15:0]     ia_s1_reg;
    logic signed [35:0]     beta_prod_reg;

    // angle bits above ANGLE_BITS are dropped, the angle wraps
    assign ang_wide = {{ANGLE_BITS{1'b0}}, sample.rotor_angle};
    assign ang      = ang_wide[ANGLE_BITS-1:0];
    assign ang_prod = PROD_W'(ang) * PROD_W'(4 * DEPTH);
    assign idx      = ang_prod[PROD_W-1:ANGLE_BITS];

    always_comb
    begin
        priority if (idx >= IDX_W'(3 * DEPTH))
        begin
            quad  = 2'd3;
            pos_w = idx - IDX_W'(3 * DEPTH);
        end
        else if (idx >= IDX_W'(2 * DEPTH))
        begin
            quad  = 2'd2;
            pos_w = idx - IDX_W'(2 * DEPTH);
        end
        else if (idx >= IDX_W'(DEPTH))
        begin
            quad  = 2'd1;
            pos_w = idx - IDX_W'(DEPTH);
        end
        else
        begin
            quad  = 2'd0;
            pos_w = idx;
        end
    end

    assign pos    = pos_w[AW-1:0];
    // cosine is the sine one quadrant ahead, same position in the quadrant
    assign cquad  = quad + 2'd1;
    assign ab_sum = 18'(sample.phase_a_current) + (18'(sample.phase_b_current) <<< 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_addr_reg   <= quad[0] ? (AW'(DEPTH) - pos) : pos;
            cos_addr_reg   <= cquad[0] ? (AW'(DEPTH) - pos) : pos;
            sin_neg_s1_reg <= quad[1];
            cos_neg_s1_reg <= cquad[1];
            ia_s1_reg      <= sample.phase_a_current;
            beta_prod_reg  <= 36'(ab_sum) * 36'(focpwm_pkg::INV_SQRT3_Q16);
        end
    end

    // ---------------------------------------------------------------
    // stage 2: sine table read, beta current scaled down
    // ---------------------------------------------------------------
    logic [focpwm_pkg::SIN_W-1:0] sin_mag;
    logic [focpwm_pkg::SIN_W-1:0] cos_mag;
    logic                         sin_neg_s2_reg;
    logic                         cos_neg_s2_reg;
    logic signed [15:0]           ia_s2_reg;
    logic signed [17:0]           ibeta_s2_reg;

    focpwm_sincos #(
        .DEPTH (DEPTH)
    ) u_sincos (
        .clk      (clk),
        .en       (en),
        .sin_addr (sin_addr_reg),
        .cos_addr (cos_addr_reg),
        .sin_mag  (sin_mag),
        .cos_mag  (cos_mag)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_neg_s2_reg <= sin_neg_s1_reg;
            cos_neg_s2_reg <= cos_neg_s1_reg;
            ia_s2_reg      <= ia_s1_reg;
            ibeta_s2_reg   <= beta_prod_reg[33:16];
        end
    end

    // ---------------------------------------------------------------
    // stage 3: park and inverse park products
    // ---------------------------------------------------------------
    logic signed [15:0] sin_s;
    logic signed [15:0] cos_s;
    logic signed [31:0] ia_c_reg;
    logic signed [31:0] ia_s_reg;
    logic signed [33:0] ib_s_reg;
    logic signed [33:0] ib_c_reg;
    logic signed [31:0] vd_c_reg;
    logic signed [31:0] vd_s_reg;
    logic signed [31:0] vq_c_reg;
    logic signed [31:0] vq_s_reg;

    assign sin_s = sin_neg_s2_reg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign cos_s = cos_neg_s2_reg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ia_c_reg <= 32'(ia_s2_reg) * 32'(cos_s);
            ia_s_reg <= 32'(ia_s2_reg) * 32'(sin_s);
            ib_s_reg <= 34'(ibeta_s2_reg) * 34'(sin_s);
            ib_c_reg <= 34'(ibeta_s2_reg) * 34'(cos_s);
            vd_c_reg <= 32'(vd_reg) * 32'(cos_s);
            vd_s_reg <= 32'(vd_reg) * 32'(sin_s);
            vq_c_reg <= 32'(vq_reg) * 32'(cos_s);
            vq_s_reg <= 32'(vq_reg) * 32'(sin_s);
        end
    end

    // ---------------------------------------------------------------
    // stage 4: sums, floor by 2^14, id/iq saturate
    // ---------------------------------------------------------------
    logic signed [34:0] id_sum;
    logic signed [34:0] iq_sum;
    logic signed [32:0] va_sum;
    logic signed [32:0] vb_sum;
    logic signed [18:0] valpha_s4_reg;
    logic signed [18:0] vbeta_s4_reg;
    focpwm_pkg::dq_t    cur_reg [NCUR];

    assign id_sum = 35'(ia_c_reg) + 35'(ib_s_reg);
    assign iq_sum = 35'(ib_c_reg) - 35'(ia_s_reg);
    assign va_sum = 33'(vd_c_reg) - 33'(vq_s_reg);
    assign vb_sum = 33'(vd_s_reg) + 33'(vq_c_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cur_reg[0].d  <= focpwm_pkg::sat16(id_sum[34:14]);
            cur_reg[0].q  <= focpwm_pkg::sat16(iq_sum[34:14]);
            valpha_s4_reg <= va_sum[32:14];
            vbeta_s4_reg  <= vb_sum[32:14];
            for (int k = 1; k < NCUR; k++)
                cur_reg[k] <= cur_reg[k-1];
        end
    end

    // ---------------------------------------------------------------
    // stage 5: beta share of phases b and c
    // ---------------------------------------------------------------
    logic signed [18:0] valpha_s5_reg;
    logic signed [36:0] vbk_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valpha_s5_reg <= valpha_s4_reg;
            vbk_reg       <= 37'(vbeta_s4_reg) * 37'(focpwm_pkg::SQRT3_HALF_Q16);
        end
    end

    // ---------------------------------------------------------------
    // stage 6: inverse clarke at scale 2^16, min-max sum
    // ---------------------------------------------------------------
    logic signed [37:0] ph_v [NPH];
    logic signed [37:0] half_a;
    logic signed [37:0] vmax;
    logic signed [37:0] vmin;
    logic signed [37:0] v_s6_reg [NPH];
    logic signed [38:0] sum_s6_reg;

    assign half_a  = 38'(valpha_s5_reg) <<< 15;
    assign ph_v[0] = 38'(valpha_s5_reg) <<< 16;
    assign ph_v[1] = 38'(vbk_reg) - half_a;
    assign ph_v[2] = -half_a - 38'(vbk_reg);

    always_comb
    begin
        vmax = ph_v[0];
        vmin = ph_v[0];
        for (int p = 1; p < NPH; p++)
        begin
            if (ph_v[p] > vmax)
                vmax = ph_v[p];
            if (ph_v[p] < vmin)
                vmin = ph_v[p];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_s6_reg   <= ph_v;
            sum_s6_reg <= 39'(vmax) + 39'(vmin);
        end
    end

    // ---------------------------------------------------------------
    // stage 7: zero-sequence offset, bias to half bus, clamp to 0..full
    // ---------------------------------------------------------------
    logic signed [40:0] inner_s [NPH];
    logic signed [40:0] full_s;
    logic [33:0]        inner_reg [NPH];

    assign full_s = $signed({8'b0, bus_eff, 17'b0});

    always_comb
    begin
        for (int p = 0; p < NPH; p++)
            inner_s[p] = (41'(v_s6_reg[p]) <<< 1) - 41'(sum_s6_reg)
                       + $signed({9'b0, bus_eff, 16'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < NPH; p++)
            begin
                priority if (inner_s[p] < 41'sd0)
                    inner_reg[p] <= '0;
                else if (inner_s[p] > full_s)
                    inner_reg[p] <= full_s[33:0];
                else
                    inner_reg[p] <= inner_s[p][33:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 8: period times clamped value, split in two halves
    // ---------------------------------------------------------------
    logic [32:0] phi_reg [NPH];
    logic [32:0] plo_reg [NPH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < NPH; p++)
            begin
                phi_reg[p] <= 33'(period_reg) * 33'(inner_reg[p][33:17]);
                plo_reg[p] <= 33'(period_reg) * 33'(inner_reg[p][16:0]);
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 9: numerator floor(period * inner / 2^17)
    // ---------------------------------------------------------------
    logic [focpwm_pkg::NUM_W-1:0] numer_reg [NPH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < NPH; p++)
                numer_reg[p] <= focpwm_pkg::NUM_W'(phi_reg[p])
                              + focpwm_pkg::NUM_W'(plo_reg[p][32:17]);
        end
    end

    // ---------------------------------------------------------------
    // stages 10 and on: divide by bus voltage, quotient is the compare
    // ---------------------------------------------------------------
    logic [focpwm_pkg::QUOT_W-1:0] quot [NPH];

    focpwm_div u_div (
        .clk     (clk),
        .en      (en),
        .numer   (numer_reg),
        .divisor (bus_eff),
        .quot    (quot)
    );

    // ---------------------------------------------------------------
    // output register with one skid entry
    // ---------------------------------------------------------------
    focpwm_pkg::result_t push_data;

    assign push_data.current_d = cur_reg[NCUR-1].d;
    assign push_data.current_q = cur_reg[NCUR-1].q;
    assign push_data.compare_a = quot[0];
    assign push_data.compare_b = quot[1];
    assign push_data.compare_c = quot[2];

    focpwm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (v_reg[NSTG-1] && en),
        .push_data (push_data),
        .space     (space),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

`ifndef ASSERT_OFF
    a_compare_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.compare_a <= period_reg && result.compare_b <= period_reg
                          && result.compare_c <= period_reg))
        else $error("compare count above pwm period");
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid)
        else $error("input stalled with no result waiting");
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("waiting result dropped or changed");
`endif

endmodule

/* hdl/focpwm_sincos.sv */
module focpwm_sincos #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [AW-1:0]                 sin_addr,
    input  logic [AW-1:0]                 cos_addr,
    output logic [focpwm_pkg::SIN_W-1:0]  sin_mag,
    output logic [focpwm_pkg::SIN_W-1:0]  cos_mag
);

    typedef logic [focpwm_pkg::SIN_W-1:0] tbl_t [0:DEPTH];

    // quarter wave, odd taylor series through x^13 in q2.30
    function automatic tbl_t build_table();
        tbl_t   tb;
        longint x;
        longint x2;
        longint t;
        longint v;
        for (int j = 0; j <= DEPTH; j++)
        begin
            if (j == DEPTH)
                tb[j] = 15'd16384;
            else
            begin
                x  = (longint'(j) * focpwm_pkg::HALF_PI_Q30) / DEPTH;
                x2 = (x * x) >>> 30;
                t  = focpwm_pkg::Q30_ONE;
                t  = focpwm_pkg::Q30_ONE - ((x2 * t) >>> 30) / 156;
                t  = focpwm_pkg::Q30_ONE - ((x2 * t) >>> 30) / 110;
                t  = focpwm_pkg::Q30_ONE - ((x2 * t) >>> 30) / 72;
                t  = focpwm_pkg::Q30_ONE - ((x2 * t) >>> 30) / 42;
                t  = focpwm_pkg::Q30_ONE - ((x2 * t) >>> 30) / 20;
                t  = focpwm_pkg::Q30_ONE - ((x2 * t) >>> 30) / 6;
                v  = (((x * t) >>> 30) + 64'sd32768) >>> 16;
                tb[j] = v[focpwm_pkg::SIN_W-1:0];
            end
        end
        return tb;
    endfunction

    localparam tbl_t TBL = build_table();

    logic [focpwm_pkg::SIN_W-1:0] sin_mag_reg;
    logic [focpwm_pkg::SIN_W-1:0] cos_mag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg <= TBL[sin_addr];
            cos_mag_reg <= TBL[cos_addr];
        end
    end

    assign sin_mag = sin_mag_reg;
    assign cos_mag = cos_mag_reg;

endmodule

/* hdl/focpwm_div.sv */
module focpwm_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic [focpwm_pkg::NUM_W-1:0]    numer [focpwm_pkg::PHASES],
    input  logic [15:0]                     divisor,
    output logic [focpwm_pkg::QUOT_W-1:0]   quot [focpwm_pkg::PHASES]
);

    localparam int NW  = focpwm_pkg::NUM_W;
    localparam int QW  = focpwm_pkg::QUOT_W;
    localparam int NST = focpwm_pkg::DIV_STAGES;
    localparam int NPH = focpwm_pkg::PHASES;

    logic [NW-1:0] rem_reg  [NST][NPH];
    logic [NW-1:0] rem_next [NST][NPH];
    logic [QW-1:0] q_reg    [NST][NPH];
    logic [QW-1:0] q_next   [NST][NPH];

    // restoring division, DIV_STEPS quotient bits per stage
    always_comb
    begin
        logic [NW-1:0] r;
        logic [QW-1:0] qq;
        logic [NW-1:0] dsh;
        int            b;
        for (int st = 0; st < NST; st++)
        begin
            for (int ph = 0; ph < NPH; ph++)
            begin
                r  = (st == 0) ? numer[ph] : rem_reg[(st == 0) ? 0 : st - 1][ph];
                qq = (st == 0) ? '0 : q_reg[(st == 0) ? 0 : st - 1][ph];
                for (int s = 0; s < focpwm_pkg::DIV_STEPS; s++)
                begin
                    b   = QW - 1 - (st * focpwm_pkg::DIV_STEPS + s);
                    dsh = NW'(divisor) << b;
                    if (r >= dsh)
                    begin
                        r     = r - dsh;
                        qq[b] = 1'b1;
                    end
                end
                rem_next[st][ph] = r;
                q_next[st][ph]   = qq;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    always_comb
    begin
        for (int ph = 0; ph < NPH; ph++)
            quot[ph] = q_reg[NST-1][ph];
    end

endmodule

/* hdl/focpwm_skid.sv */
module focpwm_skid (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  focpwm_pkg::result_t   push_data,
    output logic                  space,
    output logic                  out_valid,
    input  logic                  out_ready,
    output focpwm_pkg::result_t   out_data
);

    logic                out_valid_reg;
    logic                skid_valid_reg;
    focpwm_pkg::result_t out_data_reg;
    focpwm_pkg::result_t skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end
            else if (push)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        else if (push && !skid_valid_reg)
            skid_data_reg <= push_data;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> !skid_valid_reg)
        else $error("skid entry not drained after transfer");
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("push with skid entry already full");
`endif

endmodule

/* tb/tb_foc_open_loop_pwm_compare.sv */
module tb_foc_open_loop_pwm_compare;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1024;
    localparam int ANG_BITS    = 16;
    localparam longint CYCLE_LIMIT = 2000000;
    // index past the register map, the write must be dropped
    localparam logic [focpwm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 4'd9;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_ready;
    focpwm_pkg::sample_t sample;
    logic result_valid;
    logic result_ready;
    focpwm_pkg::result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [focpwm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    foc_open_loop_pwm_compare #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH),
        .ANGLE_BITS(ANG_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample(sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow copy of the configuration registers
    logic [15:0] bus_shadow;
    logic [15:0] vd_shadow;
    logic [15:0] vq_shadow;
    logic [15:0] period_shadow;

    // quarter-wave sine table, built once at start
    longint quarter_rom [0:TABLE_DEPTH];

    focpwm_pkg::result_t expected_results [$];
    int     mismatch_count;
    longint cycle_count;

    // idle percentages, changed per phase by the stimulus process
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int n);
        // arithmetic shift on longint floors toward minus infinity
        return v >>> n;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint taylor_sin(longint j);
        longint divs [6];
        longint x;
        longint x2;
        longint t;
        divs = '{156, 110, 72, 42, 20, 6};
        if (j >= TABLE_DEPTH)
            return 16384;
        x  = (j * 64'sd1686629713) / TABLE_DEPTH;
        x2 = (x * x) >>> 30;
        t  = 64'sd1073741824;
        for (int i = 0; i < 6; i++)
            t = 64'sd1073741824 - ((x2 * t) >>> 30) / divs[i];
        return (((x * t) >>> 30) + 32768) >>> 16;
    endfunction

    function automatic longint wave_lookup(longint idx);
        longint quad;
        longint pos;
        quad = (idx / TABLE_DEPTH) % 4;
        pos  = idx % TABLE_DEPTH;
        case (quad)
            0: return quarter_rom[pos];
            1: return quarter_rom[TABLE_DEPTH - pos];
            2: return -quarter_rom[pos];
            default: return -quarter_rom[TABLE_DEPTH - pos];
        endcase
    endfunction

    function automatic logic [15:0] duty_count(longint m, longint bus, longint period);
        longint full_scale;
        longint inner;
        full_scale = bus << 17;
        inner = (bus << 16) + m;
        if (inner < 0)
            inner = 0;
        if (inner > full_scale)
            inner = full_scale;
        return 16'((period * inner) / full_scale);
    endfunction

    // d/q currents and the three compare counts for one sample
    function automatic focpwm_pkg::result_t foc_transform(focpwm_pkg::sample_t s);
        focpwm_pkg::result_t r;
        longint ia, ib, idx, sn, cs, i_beta, vd, vq, v_al, v_be;
        longint va, vb, vc, vmax, vmin, total, bus, period;
        ia  = longint'(s.phase_a_current);
        ib  = longint'(s.phase_b_current);
        idx = (longint'(s.rotor_angle) * 4 * TABLE_DEPTH) >> ANG_BITS;
        sn  = wave_lookup(idx);
        cs  = wave_lookup((idx + TABLE_DEPTH) % (4 * TABLE_DEPTH));
        i_beta = floor_shift((ia + 2 * ib) * 37837, 16);
        r.current_d = 16'(clip16(floor_shift(ia * cs + i_beta * sn, 14)));
        r.current_q = 16'(clip16(floor_shift(-ia * sn + i_beta * cs, 14)));
        vd = longint'($signed(vd_shadow));
        vq = longint'($signed(vq_shadow));
        v_al = floor_shift(vd * cs - vq * sn, 14);
        v_be = floor_shift(vd * sn + vq * cs, 14);
        va = v_al * 65536;
        vb = -v_al * 32768 + v_be * 56756;
        vc = -v_al * 32768 - v_be * 56756;
        vmax = va;
        vmin = va;
        if (vb > vmax) vmax = vb;
        if (vc > vmax) vmax = vc;
        if (vb < vmin) vmin = vb;
        if (vc < vmin) vmin = vc;
        total  = vmax + vmin;
        // zero bus is taken as the smallest bus
        bus    = (bus_shadow == 0) ? 1 : longint'(bus_shadow);
        period = longint'(period_shadow);
        r.compare_a = duty_count(2 * va - total, bus, period);
        r.compare_b = duty_count(2 * vb - total, bus, period);
        r.compare_c = duty_count(2 * vc - total, bus, period);
        return r;
    endfunction

    task automatic write_register(logic [focpwm_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            focpwm_pkg::REG_BUS_VOLTAGE: bus_shadow    = value;
            focpwm_pkg::REG_VOLT_D_CMD:  vd_shadow     = value;
            focpwm_pkg::REG_VOLT_Q_CMD:  vq_shadow     = value;
            focpwm_pkg::REG_PWM_PERIOD:  period_shadow = value;
            default: ;
        endcase
        // a quiet clock with valid low so back-to-back writes do not drive valid twice in a step
        @(posedge clk);
    endtask

    // offer one sample, hold it until the transfer, queue the prediction
    // valid stays high on return; the next idle cycle or the drain drops it
    task automatic send_sample(focpwm_pkg::sample_t s, bit use_golden,
                               focpwm_pkg::result_t golden);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        expected_results.push_back(use_golden ? golden : foc_transform(s));
    endtask

    task automatic drain_pipe();
        sample_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // invalid writes produce nothing, give the pipe its latency
        repeat (20) @(posedge clk);
    endtask

    function automatic focpwm_pkg::sample_t random_sample();
        focpwm_pkg::sample_t s;
        case ($urandom_range(5))
            0: s.phase_a_current = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: s.phase_a_current = 16'($urandom);
        endcase
        case ($urandom_range(5))
            0: s.phase_b_current = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: s.phase_b_current = 16'($urandom);
        endcase
        s.rotor_angle = 16'($urandom);
        return s;
    endfunction

    task automatic random_config();
        write_register(focpwm_pkg::REG_BUS_VOLTAGE,
                       ($urandom_range(3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(2000, 12000)));
        write_register(focpwm_pkg::REG_VOLT_D_CMD,
                       ($urandom_range(3) == 0) ? 16'($urandom)
                                                : 16'($signed($urandom_range(0, 2048)) - 1024));
        write_register(focpwm_pkg::REG_VOLT_Q_CMD, 16'($urandom));
        write_register(focpwm_pkg::REG_PWM_PERIOD,
                       ($urandom_range(3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(100, 5000)));
    endtask

    // directed stimulus table
    typedef struct {
        logic [15:0]         a;
        logic [15:0]         b;
        logic [15:0]         ang;
        bit                  golden_known;
        focpwm_pkg::result_t golden;
    } directed_row_t;

    directed_row_t directed_rows [$];

    // result side: random stalls, one long hold-off, compare against the queue
    initial
    begin
        focpwm_pkg::result_t want;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer %p", result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", want, result);
                    end
                end
            end
            if (hold_off)
                result_ready <= 1'b0;
            else
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        focpwm_pkg::sample_t s;
        directed_row_t row;
        focpwm_pkg::result_t zero_res;
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_off       = 1'b0;
        bus_shadow     = focpwm_pkg::BUS_VOLTAGE_RST;
        vd_shadow      = focpwm_pkg::VOLT_D_CMD_RST;
        vq_shadow      = focpwm_pkg::VOLT_Q_CMD_RST;
        period_shadow  = focpwm_pkg::PWM_PERIOD_RST;
        for (int j = 0; j <= TABLE_DEPTH; j++)
            quarter_rom[j] = taylor_sin(j);

        // zero currents at angle zero under reset config: vq=3 on a 28 V bus
        zero_res = '0;
        directed_rows.push_back('{16'h0000, 16'h0000, 16'h0000, 1'b0, zero_res});
        directed_rows.push_back('{16'h7fff, 16'h7fff, 16'h0000, 1'b0, zero_res});
        directed_rows.push_back('{16'h8000, 16'h8000, 16'h0000, 1'b0, zero_res});
        directed_rows.push_back('{16'h7fff, 16'h8000, 16'h4000, 1'b0, zero_res});
        directed_rows.push_back('{16'h8000, 16'h7fff, 16'h8000, 1'b0, zero_res});
        directed_rows.push_back('{16'h7fff, 16'h7fff, 16'h2000, 1'b0, zero_res});
        directed_rows.push_back('{16'h8000, 16'h8000, 16'ha000, 1'b0, zero_res});
        directed_rows.push_back('{16'h0100, 16'hff00, 16'hc000, 1'b0, zero_res});
        directed_rows.push_back('{16'h0100, 16'h0000, 16'hffff, 1'b0, zero_res});
        directed_rows.push_back('{16'hffff, 16'h0001, 16'h0001, 1'b0, zero_res});
        directed_rows.push_back('{16'h5555, 16'haaaa, 16'h3fff, 1'b0, zero_res});
        directed_rows.push_back('{16'haaaa, 16'h5555, 16'h7fff, 1'b0, zero_res});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            s = '{row.a, row.b, row.ang};
            send_sample(s, row.golden_known, row.golden);
        end
        drain_pipe();

        // zero period gives all compares zero, regardless of currents (d/q still predicted)
        write_register(focpwm_pkg::REG_PWM_PERIOD, 16'd0);
        write_register(focpwm_pkg::REG_BUS_VOLTAGE, 16'd0);
        write_register(focpwm_pkg::REG_VOLT_D_CMD, 16'h7fff);
        write_register(focpwm_pkg::REG_VOLT_Q_CMD, 16'h8000);
        write_register(REG_UNMAPPED, 16'h1234);
        for (int i = 0; i < 4; i++)
            send_sample(random_sample(), 1'b0, zero_res);
        drain_pipe();

        // zero bus with full period: compares slam to the rails
        write_register(focpwm_pkg::REG_PWM_PERIOD, 16'hffff);
        for (int i = 0; i < 4; i++)
            send_sample(random_sample(), 1'b0, zero_res);
        drain_pipe();

        // largest bus, smallest period
        write_register(focpwm_pkg::REG_BUS_VOLTAGE, 16'hffff);
        write_register(focpwm_pkg::REG_PWM_PERIOD, 16'd1);
        write_register(focpwm_pkg::REG_VOLT_D_CMD, 16'h8000);
        write_register(focpwm_pkg::REG_VOLT_Q_CMD, 16'h7fff);
        for (int i = 0; i < 4; i++)
            send_sample(random_sample(), 1'b0, zero_res);
        drain_pipe();

        // random phases: receiver mostly idle, sender mostly idle, then flat out
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 31 : ((ph == 1) ? 86 : 0);
            recv_idle_pct = (ph == 0) ? 86 : ((ph == 1) ? 31 : 0);
            for (int blk = 0; blk < 3; blk++)
            begin
                random_config();
                for (int i = 0; i < 110; i++)
                    send_sample(random_sample(), 1'b0, zero_res);
                drain_pipe();
            end
        end

        // long receiver hold-off while samples keep coming, so the input stalls
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_sample(random_sample(), 1'b0, zero_res);
        join
        drain_pipe();

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
hdl/focpwm_pkg.sv
hdl/focpwm_sincos.sv
hdl/focpwm_div.sv
hdl/focpwm_skid.sv
hdl/foc_open_loop_pwm_compare.sv
tb/tb_foc_open_loop_pwm_compare.sv
